// ===== rtl/psc_pkg.sv =====
// Shared constants, codes and control structs of the planar sprite compositor.
// No dependencies; imported by the controller, the datapath and the top level.
package psc_pkg;

  localparam int ROW_BYTES   = 60;
  localparam int ROWS        = 240;
  localparam int PLANES      = 4;
  localparam int SLOTS       = 16;
  localparam int SPRITE_ROWS = 16;

  localparam int PLANE_BYTES = ROWS * ROW_BYTES;
  localparam int STORE_BYTES = PLANES * PLANE_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int ROFF_W      = $clog2(PLANE_BYTES);
  localparam int ROW_STEP    = ROW_BYTES - 2;
  localparam int MAX_X       = (ROW_BYTES - 3) * 8 + 7;
  localparam int MAX_Y       = ROWS - SPRITE_ROWS;
  localparam int ROW_W       = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
  localparam int PLANE_W     = 2;

  localparam logic [1:0] FUNC_MOVE = 2'd0;
  localparam logic [1:0] FUNC_DRAW = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  typedef enum logic [1:0] {
    ADV_BYTE,
    ADV_ROW,
    ADV_PLANE,
    ADV_LAST
  } adv_t;

  typedef struct packed {
    logic               clr;
    logic               load;
    logic               setup;
    logic               issue;
    adv_t               adv;
    logic [1:0]         byte_sel;
    logic [ROW_W-1:0]   row_sel;
    logic [PLANE_W-1:0] plane_sel;
    logic               rd_issue;
    logic               out_load;
  } psc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_valid;
  } psc_stat_t;

endpackage

// ===== rtl/planar_sprite_compositor.sv =====
// Top level of the planar sprite compositor: four-plane 1-bit frame store
// with sixteen sprite slots. Depends on psc_pkg, psc_ctrl and psc_datapath.
//
// Usage: items arrive on the in_ channel with valid/ready; one beat carries
// func, slot, position, plane mask, alive flag and read address. Only read
// items produce a beat on the out_ channel, carrying out_read_data.
// The cfg_ port writes one of the four 64-bit sprite pattern registers per cycle.
// Move and draw items pass through a setup state, then every byte of
// 16 rows by 3 bytes in each of the four planes is walked at one byte per
// cycle through the single read-modify-write port of the frame store;
// unmasked planes are walked with writes suppressed. Only after the last
// byte is the next item accepted. A read item waits in a read state while
// the output register holds an untaken result, then passes a response state;
// out_valid rises as the input is freed. A skipped item frees the input in the next cycle.
// After reset the frame store is cleared one byte per cycle over all 57600
// bytes, during which in_ready stays low; configuration writes are taken.
// The result sits in an output register, so new items are accepted while
// the receiver stalls; a later read waits until that register is free.
module planar_sprite_compositor
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [8:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [3:0]  in_plane_mask,
  input  logic        in_alive,
  input  logic [1:0]  in_read_plane,
  input  logic [13:0] in_read_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data
);

  psc_cmd_t  cmd;
  psc_stat_t stat;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_alive  (in_alive),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_plane_mask  (in_plane_mask),
    .in_read_plane  (in_read_plane),
    .in_read_offset (in_read_offset),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data)
  );

endmodule

// ===== rtl/psc_ctrl.sv =====
// Sequencer of the planar sprite compositor: clearing pass, item decode and
// the plane, row and byte walk of an area. Depends on psc_pkg.
module psc_ctrl
  import psc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       in_alive,
  input  logic       out_ready,
  output logic       in_ready,
  input  psc_stat_t  stat,
  output psc_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_READ,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         byte_r, byte_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic               accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    cmd       = '0;
    cmd.adv   = ADV_BYTE;
    cmd.byte_sel  = byte_r;
    cmd.row_sel   = row_r;
    cmd.plane_sel = plane_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          if (in_func == FUNC_MOVE || (in_func == FUNC_DRAW && in_alive)) begin
            state_nxt = S_SETUP;
          end else if (in_func == FUNC_READ) begin
            state_nxt = S_READ;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        byte_nxt  = '0;
        row_nxt   = '0;
        plane_nxt = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (byte_r != 2'd2) begin
          cmd.adv  = ADV_BYTE;
          byte_nxt = byte_r + 2'd1;
        end else if (row_r != ROW_W'(SPRITE_ROWS - 1)) begin
          cmd.adv  = ADV_ROW;
          byte_nxt = '0;
          row_nxt  = row_r + ROW_W'(1);
        end else if (plane_r != PLANE_W'(PLANES - 1)) begin
          cmd.adv   = ADV_PLANE;
          byte_nxt  = '0;
          row_nxt   = '0;
          plane_nxt = plane_r + PLANE_W'(1);
        end else begin
          cmd.adv   = ADV_LAST;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (!stat.out_valid || out_ready) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      byte_r  <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      state_r <= state_nxt;
      byte_r  <= byte_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

endmodule

// ===== rtl/psc_datapath.sv =====
// Datapath of the planar sprite compositor: frame store memory, slot
// positions, pattern registers, address walk and read-modify-write pipeline.
// Depends on psc_pkg; driven by psc_ctrl through psc_cmd_t.
module psc_datapath
  import psc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  psc_cmd_t                   cmd,
  output psc_stat_t                  stat,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [63:0]                cfg_wdata,
  input  logic [1:0]                 in_func,
  input  logic [3:0]                 in_slot,
  input  logic [8:0]                 in_pos_x,
  input  logic [7:0]                 in_pos_y,
  input  logic [3:0]                 in_plane_mask,
  input  logic [1:0]                 in_read_plane,
  input  logic [13:0]                in_read_offset,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [7:0]                 out_read_data
);

  logic [7:0]        mem [STORE_BYTES];
  logic [63:0]       sprite_r [4];
  logic [8:0]        last_col_r [SLOTS];
  logic [7:0]        last_row_r [SLOTS];

  logic [3:0]        slot_r;
  logic [8:0]        new_x_r, area_x_r;
  logic [7:0]        new_y_r, area_y_r;
  logic [3:0]        mask_r;
  logic              erase_r;
  logic [ADDR_W-1:0] read_addr_r;
  logic              read_bad_r;

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] plane_base_r, plane_base_nxt;
  logic [ROFF_W-1:0] row_off_r, row_off_calc;

  logic [ADDR_W-1:0] pend_addr_r;
  logic [7:0]        pend_byte_r;
  logic              pend_valid_r;
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_valid_r;
  logic [7:0]        out_data_r;

  logic [8:0]        clamp_x;
  logic [7:0]        clamp_y;
  logic [15:0]       pat_row;
  logic [23:0]       pat_win;
  logic [7:0]        pat_byte;

  assign clamp_x = (in_pos_x > 9'(MAX_X)) ? 9'(MAX_X) : in_pos_x;
  assign clamp_y = (in_pos_y > 8'(MAX_Y)) ? 8'(MAX_Y) : in_pos_y;

  assign row_off_calc = ROFF_W'(area_y_r) * ROFF_W'(ROW_BYTES) + ROFF_W'(area_x_r[8:3]);

  assign pat_row = sprite_r[cmd.row_sel[3:2]][16*cmd.row_sel[1:0] +: 16];
  assign pat_win = {pat_row, 8'h00} >> area_x_r[2:0];

  always_comb begin
    case (cmd.byte_sel)
      2'd0:    pat_byte = pat_win[23:16];
      2'd1:    pat_byte = pat_win[15:8];
      default: pat_byte = pat_win[7:0];
    endcase
  end

  always_comb begin
    addr_nxt       = addr_r;
    plane_base_nxt = plane_base_r;
    if (cmd.clr) begin
      addr_nxt = addr_r + ADDR_W'(1);
    end else if (cmd.setup) begin
      addr_nxt       = ADDR_W'(row_off_calc);
      plane_base_nxt = '0;
    end else if (cmd.issue) begin
      case (cmd.adv)
        ADV_BYTE: addr_nxt = addr_r + ADDR_W'(1);
        ADV_ROW:  addr_nxt = addr_r + ADDR_W'(ROW_STEP);
        ADV_PLANE: begin
          plane_base_nxt = plane_base_r + ADDR_W'(PLANE_BYTES);
          addr_nxt       = plane_base_nxt + ADDR_W'(row_off_r);
        end
        default: addr_nxt = addr_r;
      endcase
    end
  end

  assign rd_addr = cmd.rd_issue ? read_addr_r : addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      plane_base_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sprite_r[i] <= '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        last_col_r[i] <= '0;
        last_row_r[i] <= '0;
      end
    end else begin
      addr_r       <= addr_nxt;
      plane_base_r <= plane_base_nxt;
      pend_valid_r <= cmd.issue && mask_r[cmd.plane_sel];
      if (cfg_we) begin
        sprite_r[cfg_index] <= cfg_wdata;
      end
      if (cmd.setup && erase_r) begin
        last_col_r[slot_r] <= new_x_r;
        last_row_r[slot_r] <= new_y_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r      <= in_slot;
      new_x_r     <= clamp_x;
      new_y_r     <= clamp_y;
      mask_r      <= in_plane_mask;
      erase_r     <= (in_func == FUNC_MOVE);
      read_addr_r <= ADDR_W'(in_read_plane) * ADDR_W'(PLANE_BYTES) + ADDR_W'(in_read_offset);
      read_bad_r  <= (in_read_offset >= 14'(PLANE_BYTES));
      if (in_func == FUNC_MOVE) begin
        area_x_r <= last_col_r[in_slot];
        area_y_r <= last_row_r[in_slot];
      end else begin
        area_x_r <= clamp_x;
        area_y_r <= clamp_y;
      end
    end
    if (cmd.setup) begin
      row_off_r <= row_off_calc;
    end
    pend_addr_r <= addr_r;
    pend_byte_r <= pat_byte;
    if (cmd.out_load) begin
      out_data_r <= read_bad_r ? 8'h00 : rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[addr_r] <= 8'h00;
    end else if (pend_valid_r) begin
      mem[pend_addr_r] <= erase_r ? 8'h00 : (rd_data_r | pend_byte_r);
    end
    rd_data_r <= mem[rd_addr];
  end

  assign stat.clr_done  = (addr_r == ADDR_W'(STORE_BYTES - 1));
  assign stat.out_valid = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;

endmodule
